@@ src/lz78pc_pkg.sv @@
package lz78pc_pkg;

  // Field widths
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned MAX_PHRASES = 4096;
  localparam int unsigned CNT_W       = 13;
  localparam int unsigned NODE_W      = $clog2(MAX_PHRASES + 1);

  // Hash table: twice the phrase capacity, so a probe chain always ends
  localparam int unsigned TAB_W     = $clog2(MAX_PHRASES) + 1;
  localparam int unsigned TAB_DEPTH = 1 << TAB_W;

  // Generation tag; zero marks a swept entry and is never a live tag
  localparam int unsigned EPOCH_W   = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};

  // One table slot: (parent, symbol) key and the child node it names
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [NODE_W-1:0]  parent;
    logic [SYM_W-1:0]   sym;
    logic [NODE_W-1:0]  child;
  } entry_t;

  // Table access for one cycle
  typedef struct packed {
    logic              re;
    logic [TAB_W-1:0]  raddr;
    logic              we;
    logic [TAB_W-1:0]  waddr;
    entry_t            wdata;
  } mem_req_t;

  // Result of one symbol
  typedef struct packed {
    logic [CNT_W-1:0] phrase_count;
    logic             phrase_ended;
    logic             store_full;
  } res_t;

  // Home slot of a (parent, symbol) key
  function automatic logic [TAB_W-1:0] slot_hash(logic [NODE_W-1:0] node,
                                                 logic [SYM_W-1:0]  sym);
    logic [TAB_W-1:0] spread;
    spread = {sym, sym[SYM_W-1 -: (TAB_W - SYM_W)]};
    return TAB_W'(node) ^ spread;
  endfunction

endpackage

@@ src/lz78pc_if.sv @@
// Symbol request channel
interface lz78pc_in_if;
  logic                          valid;
  logic                          ready;
  logic [lz78pc_pkg::SYM_W-1:0]  symbol;
  logic                          first;

  modport source (output valid, symbol, first, input ready);
  modport sink   (input valid, symbol, first, output ready);
endinterface

// Result channel
interface lz78pc_out_if;
  logic                          valid;
  logic                          ready;
  logic [lz78pc_pkg::CNT_W-1:0]  phrase_count;
  logic                          phrase_ended;
  logic                          store_full;

  modport source (output valid, phrase_count, phrase_ended, store_full, input ready);
  modport sink   (input valid, phrase_count, phrase_ended, store_full, output ready);
endinterface

@@ src/lz78_phrase_complexity_unit.sv @@
// Channel  Dir  Payload                                    Accept
// sym_i    in   symbol[7:0], first                         valid && ready
// res_o    out  phrase_count[12:0], phrase_ended, store_full  valid && ready
//
// A symbol is looked up in the cycle after acceptance and the next symbol is taken in that
// same cycle: one symbol per cycle while no slot is probed past a collision, as each extra
// probe is a further read (single read port). A resolved result is written to the output
// register. After reset, and when the 8-bit generation tag runs out on a first symbol,
// a sweep of all 8192 table slots runs while no symbol is accepted.
// A held result stalls the lookup, which in turn holds off new symbols.
module lz78_phrase_complexity_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  lz78pc_in_if.sink     sym_i,
  lz78pc_out_if.source  res_o
);

  lz78pc_pkg::mem_req_t mem_req;
  lz78pc_pkg::entry_t   rd_data;
  lz78pc_pkg::res_t     res;
  logic                 res_push;
  logic                 out_free;

  lz78pc_tab u_tab (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  lz78pc_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sym_i.valid),
    .in_symbol_i (sym_i.symbol),
    .in_first_i  (sym_i.first),
    .in_ready_o  (sym_i.ready),
    .out_free_i  (out_free),
    .rd_data_i   (rd_data),
    .mem_req_o   (mem_req),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  lz78pc_obuf u_obuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .free_o (out_free),
    .res_o  (res_o)
  );

endmodule

@@ src/lz78pc_tab.sv @@
// Phrase hash table: one write port, one read port, registered read data
module lz78pc_tab (
  input  logic                  clk_i,
  input  lz78pc_pkg::mem_req_t  req_i,
  output lz78pc_pkg::entry_t    rd_data_o
);

  lz78pc_pkg::entry_t mem [lz78pc_pkg::TAB_DEPTH];
  lz78pc_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

@@ src/lz78pc_parse.sv @@
// Parser control: hashed lookup with linear probing, insert, generation sweep
module lz78pc_parse (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [lz78pc_pkg::SYM_W-1:0]      in_symbol_i,
  input  logic                              in_first_i,
  output logic                              in_ready_o,
  input  logic                              out_free_i,
  input  lz78pc_pkg::entry_t                rd_data_i,
  output lz78pc_pkg::mem_req_t              mem_req_o,
  output logic                              res_push_o,
  output lz78pc_pkg::res_t                  res_o
);

  localparam int unsigned NODE_W  = lz78pc_pkg::NODE_W;
  localparam int unsigned CNT_W   = lz78pc_pkg::CNT_W;
  localparam int unsigned TAB_W   = lz78pc_pkg::TAB_W;
  localparam int unsigned SYM_W   = lz78pc_pkg::SYM_W;
  localparam int unsigned EPOCH_W = lz78pc_pkg::EPOCH_W;

  // Control state
  logic               busy_q, busy_d;
  logic               clr_q, clr_d;
  logic               pend_q, pend_d;
  logic [TAB_W-1:0]   clr_addr_q, clr_addr_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [NODE_W-1:0]  node_q, node_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               full_q, full_d;
  logic               fwd_q, fwd_d;

  // Lookup key and slot of the read in flight
  logic [TAB_W-1:0]   slot_q, slot_d;
  logic [NODE_W-1:0]  par_q, par_d;
  logic [SYM_W-1:0]   sym_q, sym_d;
  logic [TAB_W-1:0]   fwd_slot_q;
  lz78pc_pkg::entry_t fwd_ent_q;

  lz78pc_pkg::entry_t   ent;
  lz78pc_pkg::mem_req_t req;
  logic               live, match, decide, resolve, room, ended, ins;
  logic               clr_last, in_ready, accept, wrap;
  logic [NODE_W-1:0]  node_r, base;
  logic [CNT_W-1:0]   cnt_r;
  logic               full_r;

  always_comb begin
    // Slot contents, bypassing a write made in the cycle the read was issued
    ent   = (fwd_q && (fwd_slot_q == slot_q)) ? fwd_ent_q : rd_data_i;
    live  = (ent.epoch == epoch_q);
    match = live && (ent.parent == par_q) && (ent.sym == sym_q);

    decide  = busy_q && (match || !live);
    resolve = decide && out_free_i;
    room    = (cnt_q < CNT_W'(lz78pc_pkg::MAX_PHRASES));

    // Outcome of the current lookup
    node_r = node_q;
    cnt_r  = cnt_q;
    full_r = full_q;
    ended  = 1'b0;
    ins    = 1'b0;
    if (match) begin
      node_r = ent.child;
    end else begin
      node_r = '0;
      if (room) begin
        cnt_r = CNT_W'(cnt_q + 1'b1);
        ended = 1'b1;
        ins   = 1'b1;
      end else begin
        full_r = 1'b1;
      end
    end

    clr_last = clr_q && (clr_addr_q == {TAB_W{1'b1}});
    in_ready = !clr_q && !pend_q && (!busy_q || resolve);
    accept   = in_valid_i && in_ready;
    base     = in_first_i ? '0 : (resolve ? node_r : node_q);
    wrap     = in_first_i && (epoch_q == lz78pc_pkg::EPOCH_MAX);

    // Next state
    busy_d     = busy_q;
    clr_d      = clr_q;
    pend_d     = pend_q;
    clr_addr_d = clr_addr_q;
    epoch_d    = epoch_q;
    node_d     = node_q;
    cnt_d      = cnt_q;
    full_d     = full_q;
    slot_d     = slot_q;
    par_d      = par_q;
    sym_d      = sym_q;

    if (resolve) begin
      node_d = node_r;
      cnt_d  = cnt_r;
      full_d = full_r;
      busy_d = 1'b0;
    end

    // Occupied by another key: step to the next slot
    if (busy_q && live && !match) begin
      slot_d = TAB_W'(slot_q + 1'b1);
    end

    if (accept) begin
      par_d = base;
      sym_d = in_symbol_i;
      if (in_first_i) begin
        cnt_d  = '0;
        full_d = 1'b0;
        node_d = '0;
      end
      if (wrap) begin
        // Tags exhausted: sweep the table before this symbol
        clr_d      = 1'b1;
        clr_addr_d = '0;
        pend_d     = 1'b1;
        epoch_d    = lz78pc_pkg::EPOCH_FIRST;
        busy_d     = 1'b0;
      end else begin
        if (in_first_i) begin
          epoch_d = EPOCH_W'(epoch_q + 1'b1);
        end
        busy_d = 1'b1;
        slot_d = lz78pc_pkg::slot_hash(base, in_symbol_i);
      end
    end

    // Sweep
    if (clr_q) begin
      clr_addr_d = TAB_W'(clr_addr_q + 1'b1);
      if (clr_last) begin
        clr_d = 1'b0;
        if (pend_q) begin
          pend_d = 1'b0;
          busy_d = 1'b1;
          slot_d = lz78pc_pkg::slot_hash(par_q, sym_q);
        end
      end
    end

    // Table access
    req.re    = busy_d;
    req.raddr = slot_d;
    req.we    = clr_q || (resolve && ins);
    req.waddr = clr_q ? clr_addr_q : slot_q;
    if (clr_q) begin
      req.wdata = '0;
    end else begin
      req.wdata.epoch  = epoch_q;
      req.wdata.parent = par_q;
      req.wdata.sym    = sym_q;
      req.wdata.child  = NODE_W'(cnt_r);
    end
    fwd_d = req.we;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      clr_q      <= 1'b1;
      pend_q     <= 1'b0;
      clr_addr_q <= '0;
      epoch_q    <= lz78pc_pkg::EPOCH_FIRST;
      node_q     <= '0;
      cnt_q      <= '0;
      full_q     <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      clr_q      <= clr_d;
      pend_q     <= pend_d;
      clr_addr_q <= clr_addr_d;
      epoch_q    <= epoch_d;
      node_q     <= node_d;
      cnt_q      <= cnt_d;
      full_q     <= full_d;
      fwd_q      <= fwd_d;
    end
  end

  // Key and bypass payload
  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    par_q      <= par_d;
    sym_q      <= sym_d;
    fwd_slot_q <= req.waddr;
    fwd_ent_q  <= req.wdata;
  end

  assign in_ready_o          = in_ready;
  assign mem_req_o           = req;
  assign res_push_o          = resolve;
  assign res_o.phrase_count  = cnt_r;
  assign res_o.phrase_ended  = ended;
  assign res_o.store_full    = full_r;

endmodule

@@ src/lz78pc_obuf.sv @@
// Output register between the parser and the result channel
module lz78pc_obuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lz78pc_pkg::res_t     data_i,
  output logic                 free_o,
  lz78pc_out_if.source         res_o
);

  logic             valid_q, valid_d;
  lz78pc_pkg::res_t data_q;

  assign free_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.phrase_count = data_q.phrase_count;
  assign res_o.phrase_ended = data_q.phrase_ended;
  assign res_o.store_full   = data_q.store_full;

endmodule
